// File: hdl/pfc_pkg.sv
// Shared constants and types for the Playfair digraph cipher.
// No dependencies; imported by pfc_pair_xform and playfair_digraph_cipher.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int LETTER_W    = 5;
    localparam int COORD_W     = $clog2(SQUARE_SIDE);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 45;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_FIRST = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_MIDDLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_FINAL = 3'd3;

    // key square, [row][column]; cell 0 in the lowest bits
    typedef logic [SQUARE_SIDE-1:0][SQUARE_SIDE-1:0][LETTER_W-1:0] square_t;

    // transformed digraph
    typedef struct packed {
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
        logic                absent;
    } pair_result_t;

endpackage

// File: hdl/pfc_pair_xform.sv
// Combinational Playfair transform of one digraph over the key square.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_pair_xform
(
    input  pfc_pkg::square_t                  square,
    input  logic                              direction,
    input  logic [pfc_pkg::LETTER_W-1:0]      first,
    input  logic [pfc_pkg::LETTER_W-1:0]      second,
    output pfc_pkg::pair_result_t             result
);
    import pfc_pkg::*;

    logic [COORD_W-1:0] row_a, col_a, row_b, col_b;
    logic               found_a, found_b;

    // one step with wrap, forward or backward
    function automatic logic [COORD_W-1:0] shift_coord(input logic [COORD_W-1:0] v,
                                                       input logic dir);
        logic [COORD_W-1:0] res;
        if (!dir)
        begin
            res = (v == COORD_W'(SQUARE_SIDE - 1)) ? '0 : v + COORD_W'(1);
        end
        else
        begin
            res = (v == '0) ? COORD_W'(SQUARE_SIDE - 1) : v - COORD_W'(1);
        end
        return res;
    endfunction

    // descending scan: lowest matching cell wins; absent sits at 0,0
    always_comb
    begin
        row_a   = '0;
        col_a   = '0;
        row_b   = '0;
        col_b   = '0;
        found_a = 1'b0;
        found_b = 1'b0;
        for (int r = SQUARE_SIDE - 1; r >= 0; r--)
        begin
            for (int c = SQUARE_SIDE - 1; c >= 0; c--)
            begin
                if (square[r][c] == first)
                begin
                    row_a   = COORD_W'(r);
                    col_a   = COORD_W'(c);
                    found_a = 1'b1;
                end
                if (square[r][c] == second)
                begin
                    row_b   = COORD_W'(r);
                    col_b   = COORD_W'(c);
                    found_b = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.absent = !(found_a && found_b);
        priority if (row_a == row_b)
        begin
            result.letter_a = square[row_a][shift_coord(col_a, direction)];
            result.letter_b = square[row_b][shift_coord(col_b, direction)];
        end
        else if (col_a == col_b)
        begin
            result.letter_a = square[shift_coord(row_a, direction)][col_a];
            result.letter_b = square[shift_coord(row_b, direction)][col_b];
        end
        else
        begin
            result.letter_a = square[row_a][col_b];
            result.letter_b = square[row_b][col_a];
        end
    end

endmodule

// File: hdl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: pairing, job and output stages.
// Depends on pfc_pkg and pfc_pair_xform.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid / in_stall): one letter per request, 0 = A .. 25 = Z,
//  J folded to I, message_end on the last letter. A letter is taken at a rising
//  edge with in_valid high and in_stall low.
//  Output channel (out_valid / out_stall): one cipher letter per request, with
//  final_of_message on the last letter of a message and not_in_square on both
//  letters of a digraph that had a letter missing from the key square.
//  Config channel (cfg_valid / cfg_ready): cfg_ready is always high; index 0 is
//  direction, 1..3 the square cells. Write only while the block is idle.
//  A digraph runs through a job register and then the output buffer before its
//  first letter appears. The output buffer gives one letter per cycle while
//  out_stall is low; a request causes 0, 2 or 4 letters, and the block can take
//  a new request while earlier letters are still being sent.
//  When the receiver stalls, the output buffer holds, the job register fills
//  and then in_stall rises until the buffer drains.
//  Reset clears the pending letter, both stages and all config registers.

module playfair_digraph_cipher
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pfc_pkg::LETTER_W-1:0]      in_letter,
    input  logic                              message_end,
    // output requests
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pfc_pkg::LETTER_W-1:0]      out_letter,
    output logic                              final_of_message,
    output logic                              not_in_square,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pfc_pkg::*;

    // configuration
    logic                direction_reg;
    logic [44:0]         cells_first_reg;
    logic [39:0]         cells_middle_reg;
    logic [39:0]         cells_final_reg;
    square_t             square;

    // pending letter
    logic                pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0] pend_letter_reg, pend_letter_next;

    // job stage: one or two digraphs awaiting the transform
    logic                job_valid_reg, job_valid_next;
    logic                job_two_reg, job_two_next;
    logic                job_end_reg, job_end_next;
    logic [LETTER_W-1:0] job_a0_reg, job_b0_reg, job_a1_reg, job_b1_reg;
    logic [LETTER_W-1:0] job_a0_next, job_b0_next, job_a1_next, job_b1_next;
    logic                job_has_pairs;

    // output buffer
    logic                buf_valid_reg, buf_valid_next;
    logic                buf_two_reg;
    logic                buf_end_reg;
    logic [1:0]          buf_idx_reg, buf_idx_next;
    logic [LETTER_W-1:0] buf_letter_reg [4];
    logic [1:0]          buf_flag_reg;

    logic [LETTER_W-1:0] folded;
    logic                in_take, out_take, buf_last, buf_free, job_move, job_load;
    pair_result_t        res0, res1;

    assign cfg_ready = 1'b1;
    assign square   = square_t'({cells_final_reg, cells_middle_reg, cells_first_reg});
    assign folded   = (in_letter == LETTER_J) ? LETTER_I : in_letter;

    assign buf_last = (buf_idx_reg == {buf_two_reg, 1'b1});
    assign out_take = buf_valid_reg && !out_stall;
    assign buf_free = !buf_valid_reg || (out_take && buf_last);
    assign job_move = job_valid_reg && buf_free;
    assign in_stall = job_valid_reg && !job_move;
    assign in_take  = in_valid && !in_stall;
    assign job_load = in_take && job_has_pairs;

    // digraph formation
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        job_has_pairs    = 1'b0;
        job_two_next     = 1'b0;
        job_end_next     = message_end;
        job_a0_next      = pend_letter_reg;
        job_b0_next      = folded;
        job_a1_next      = folded;
        job_b1_next      = LETTER_X;
        if (in_take)
        begin
            priority if (!pend_valid_reg)
            begin
                if (message_end)
                begin
                    job_has_pairs = 1'b1;
                    job_a0_next   = folded;
                    job_b0_next   = LETTER_X;
                end
                else
                begin
                    pend_valid_next  = 1'b1;
                    pend_letter_next = folded;
                end
            end
            else if (!direction_reg && pend_letter_reg == folded)
            begin
                // doubled letter: split with X
                job_has_pairs = 1'b1;
                job_b0_next   = LETTER_X;
                if (message_end)
                begin
                    job_two_next     = 1'b1;
                    pend_valid_next  = 1'b0;
                    pend_letter_next = '0;
                end
                else
                begin
                    pend_letter_next = folded;
                end
            end
            else
            begin
                job_has_pairs    = 1'b1;
                pend_valid_next  = 1'b0;
                pend_letter_next = '0;
            end
        end
    end

    assign job_valid_next = job_load || (job_valid_reg && !job_move);

    always_comb
    begin
        buf_valid_next = job_move || (buf_valid_reg && !(out_take && buf_last));
        buf_idx_next   = buf_idx_reg;
        if (job_move)
        begin
            buf_idx_next = '0;
        end
        else if (out_take)
        begin
            buf_idx_next = buf_idx_reg + 2'd1;
        end
    end

    pfc_pair_xform u_pair0
    (
        .square    (square),
        .direction (direction_reg),
        .first     (job_a0_reg),
        .second    (job_b0_reg),
        .result    (res0)
    );

    pfc_pair_xform u_pair1
    (
        .square    (square),
        .direction (direction_reg),
        .first     (job_a1_reg),
        .second    (job_b1_reg),
        .result    (res1)
    );

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 1'b0;
            cells_first_reg  <= '0;
            cells_middle_reg <= '0;
            cells_final_reg  <= '0;
            pend_valid_reg   <= 1'b0;
            pend_letter_reg  <= '0;
            job_valid_reg    <= 1'b0;
            buf_valid_reg    <= 1'b0;
            buf_idx_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DIRECTION:    direction_reg    <= cfg_data[0];
                    CFG_CELLS_FIRST:  cells_first_reg  <= cfg_data[44:0];
                    CFG_CELLS_MIDDLE: cells_middle_reg <= cfg_data[39:0];
                    CFG_CELLS_FINAL:  cells_final_reg  <= cfg_data[39:0];
                    default:          ;
                endcase
            end
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            job_valid_reg   <= job_valid_next;
            buf_valid_reg   <= buf_valid_next;
            buf_idx_reg     <= buf_idx_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_two_reg <= job_two_next;
            job_end_reg <= job_end_next;
            job_a0_reg  <= job_a0_next;
            job_b0_reg  <= job_b0_next;
            job_a1_reg  <= job_a1_next;
            job_b1_reg  <= job_b1_next;
        end
        if (job_move)
        begin
            buf_two_reg       <= job_two_reg;
            buf_end_reg       <= job_end_reg;
            buf_letter_reg[0] <= res0.letter_a;
            buf_letter_reg[1] <= res0.letter_b;
            buf_letter_reg[2] <= res1.letter_a;
            buf_letter_reg[3] <= res1.letter_b;
            buf_flag_reg      <= {res1.absent, res0.absent};
        end
    end

    assign out_valid        = buf_valid_reg;
    assign out_letter       = buf_letter_reg[buf_idx_reg];
    assign final_of_message = buf_end_reg && buf_last;
    assign not_in_square    = buf_flag_reg[buf_idx_reg[1]];

    // checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg && !buf_two_reg |-> !buf_idx_reg[1])
        else $error("output index beyond single digraph");

    a_stall_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> job_valid_reg && buf_valid_reg)
        else $error("input stalled with room downstream");

    a_end_drops_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && message_end |=> !pend_valid_reg)
        else $error("pending letter kept past message end");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_move |=> job_valid_reg)
        else $error("job lost without moving to output buffer");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_of_message |-> buf_idx_reg[0])
        else $error("final mark on first letter of a digraph");

endmodule
